[hdl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler angle block
// Fixed-point formats, the arctangent table and the word types that travel
// between the square-root and CORDIC cells.
// ----------------------------------------------------------------------------
package qte_pkg;

   // fixed-point formats
   localparam int QUAT_BITS       = 16;
   localparam int QUAT_FRAC_BITS  = 14;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANG_BITS        = 30;
   localparam int PROD_BITS       = 2 * QUAT_BITS;
   localparam int SUM_BITS        = PROD_BITS + 2;
   localparam int VEC_BITS        = SUM_BITS + 2;
   localparam int ACC_BITS        = 36;
   localparam int RAD_BITS        = SUM_BITS;
   localparam int ROOT_BITS       = RAD_BITS / 2;
   localparam int REM_BITS        = ROOT_BITS + 3;
   localparam int ROLL_BITS       = 16;
   localparam int PITCH_BITS      = 15;
   localparam int YAW_BITS        = 16;
   localparam int ATAN_IDX_BITS   = 5;
   localparam int OUT_SHIFT       = ANG_BITS - ANGLE_FRAC_BITS;

   localparam logic signed [SUM_BITS-1:0] ONE_Q = SUM_BITS'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
   localparam logic signed [ACC_BITS-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ACC_BITS-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF  =
      ACC_BITS'(64'sd1 <<< (OUT_SHIFT - 1));
   localparam logic signed [ACC_BITS-1:0] PI_LIM      = (PI_Q30 + ROUND_HALF) >>> OUT_SHIFT;
   localparam logic signed [ACC_BITS-1:0] HALF_PI_LIM =
      (HALF_PI_Q30 + ROUND_HALF) >>> OUT_SHIFT;

   // word moving through a CORDIC cell
   typedef struct packed {
      logic signed [VEC_BITS-1:0] x;
      logic signed [VEC_BITS-1:0] y;
      logic signed [ACC_BITS-1:0] ang;
      logic                       zero;
   } cordic_vec_type;

   // word moving through a square-root cell
   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } sqrt_vec_type;

   // atan2 operand pair
   typedef struct packed {
      logic signed [SUM_BITS-1:0] num;
      logic signed [SUM_BITS-1:0] den;
   } atan_pair_type;

   // atan(2^-i) in radians, 30 fraction bits, truncated; entries 27 to 30 rounded up
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_BITS-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h3243F6A8;
         5'd1:    v = 32'h1DAC6705;
         5'd2:    v = 32'h0FADBAFC;
         5'd3:    v = 32'h07F56EA6;
         5'd4:    v = 32'h03FEAB76;
         5'd5:    v = 32'h01FFD55B;
         5'd6:    v = 32'h00FFFAAA;
         5'd7:    v = 32'h007FFF55;
         5'd8:    v = 32'h003FFFEA;
         5'd9:    v = 32'h001FFFFD;
         5'd10:   v = 32'h000FFFFF;
         5'd11:   v = 32'h0007FFFF;
         5'd12:   v = 32'h0003FFFF;
         5'd13:   v = 32'h0001FFFF;
         5'd14:   v = 32'h0000FFFF;
         5'd15:   v = 32'h00007FFF;
         5'd16:   v = 32'h00003FFF;
         5'd17:   v = 32'h00001FFF;
         5'd18:   v = 32'h00000FFF;
         5'd19:   v = 32'h000007FF;
         5'd20:   v = 32'h000003FF;
         5'd21:   v = 32'h000001FF;
         5'd22:   v = 32'h000000FF;
         5'd23:   v = 32'h0000007F;
         5'd24:   v = 32'h0000003F;
         5'd25:   v = 32'h0000001F;
         5'd26:   v = 32'h0000000F;
         5'd27:   v = 32'h00000008;
         5'd28:   v = 32'h00000004;
         5'd29:   v = 32'h00000002;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[hdl/qte_if.sv]
// ----------------------------------------------------------------------------
// qte_if: request and response channels
// Valid/ready channels carrying one quaternion word and one angle word.
// ----------------------------------------------------------------------------
interface qte_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qte_pkg::QUAT_BITS-1:0]    quat_w;
   logic signed [qte_pkg::QUAT_BITS-1:0]    quat_x;
   logic signed [qte_pkg::QUAT_BITS-1:0]    quat_y;
   logic signed [qte_pkg::QUAT_BITS-1:0]    quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qte_pkg::ROLL_BITS-1:0]    roll_angle;
   logic signed [qte_pkg::PITCH_BITS-1:0]   pitch_angle;
   logic signed [qte_pkg::YAW_BITS-1:0]     yaw_angle;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

[hdl/qte_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one digit of a pipelined floor square root
// Brings in two radicand bits and decides one root bit per cell.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
   input  logic                  clock,
   input  logic                  enable,
   input  qte_pkg::sqrt_vec_type in_vec,
   output qte_pkg::sqrt_vec_type out_vec
);

   logic [qte_pkg::REM_BITS-1:0] cur;
   logic [qte_pkg::REM_BITS-1:0] trial;
   qte_pkg::sqrt_vec_type        out_in;
   qte_pkg::sqrt_vec_type        out_ff;

   // trial subtract of (root*4 + 1)
   always_comb begin
      cur   = {in_vec.rem[qte_pkg::REM_BITS-3:0],
               in_vec.rad[qte_pkg::RAD_BITS-1 -: 2]};
      trial = qte_pkg::REM_BITS'({in_vec.root, 2'b01});
      out_in.rad = {in_vec.rad[qte_pkg::RAD_BITS-3:0], 2'b00};
      if (cur >= trial) begin
         out_in.rem  = cur - trial;
         out_in.root = {in_vec.root[qte_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         out_in.rem  = cur;
         out_in.root = {in_vec.root[qte_pkg::ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out_vec = out_ff;

endmodule

[hdl/qte_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    enable,
   input  qte_pkg::cordic_vec_type in_vec,
   output qte_pkg::cordic_vec_type out_vec
);

   logic signed [qte_pkg::VEC_BITS-1:0] dx;
   logic signed [qte_pkg::VEC_BITS-1:0] dy;
   logic signed [qte_pkg::ACC_BITS-1:0] at;
   qte_pkg::cordic_vec_type             out_in;
   qte_pkg::cordic_vec_type             out_ff;

   // clockwise when y residue is non-negative
   always_comb begin
      dx = in_vec.y >>> STEP;
      dy = in_vec.x >>> STEP;
      at = qte_pkg::ACC_BITS'(qte_pkg::atan_entry(qte_pkg::ATAN_IDX_BITS'(STEP)));
      out_in.zero = in_vec.zero;
      if (!in_vec.y[qte_pkg::VEC_BITS-1]) begin
         out_in.x   = in_vec.x + dx;
         out_in.y   = in_vec.y - dy;
         out_in.ang = in_vec.ang + at;
      end else begin
         out_in.x   = in_vec.x - dx;
         out_in.y   = in_vec.y + dy;
         out_in.ang = in_vec.ang - at;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign out_vec = out_ff;

endmodule

[hdl/quaternion_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: unit quaternion to roll, pitch and yaw
// Pipelined products, square-root cells and three rows of CORDIC cells.
// ----------------------------------------------------------------------------
// req_chan takes one quaternion word (w, x, y, z, signed Q1.14) per cycle
// while ready is high; rsp_chan gives roll and yaw in signed Q2.13 and
// pitch in signed Q1.13, all in radians, one word per input word, in order.
// The pipe holds one product stage, one sum stage, 17 square-root cells
// for the pitch radicands, one atan2 setup stage, CORDIC_STEPS cells and
// one rounding/output register.
// Throughput is one word per cycle; every stage is a register with its own
// valid bit, so a new word enters each cycle while the pipe moves.
// When rsp_chan stalls, the words pile up toward the output and empty
// stages keep filling; req_chan.ready drops only once every stage holds a
// word. Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic      clock,
   input  logic      reset,
   qte_req_if.sink   req_chan,
   qte_rsp_if.source rsp_chan
);

   localparam int SQ_STAGES = qte_pkg::ROOT_BITS;
   localparam int PREP_IDX  = 2 + SQ_STAGES;
   localparam int OUT_IDX   = PREP_IDX + CORDIC_STEPS + 1;
   localparam int NSTAGES   = OUT_IDX + 1;

   // stage valid bits and moving enables
   logic [NSTAGES-1:0] valid_ff;
   logic [NSTAGES-1:0] valid_in;
   logic [NSTAGES:0]   en;

   always_comb begin
      en[NSTAGES] = rsp_chan.ready;
      for (int k = NSTAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      for (int k = 0; k < NSTAGES; k++) begin
         if (k == 0) begin
            valid_in[k] = en[k] ? req_chan.valid : valid_ff[k];
         end else begin
            valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = en[0];

   // product stage
   logic signed [qte_pkg::PROD_BITS-1:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff;
   logic signed [qte_pkg::PROD_BITS-1:0] wy_ff, xz_ff, wz_ff, xy_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         wx_ff <= req_chan.quat_w * req_chan.quat_x;
         yz_ff <= req_chan.quat_y * req_chan.quat_z;
         xx_ff <= req_chan.quat_x * req_chan.quat_x;
         yy_ff <= req_chan.quat_y * req_chan.quat_y;
         zz_ff <= req_chan.quat_z * req_chan.quat_z;
         wy_ff <= req_chan.quat_w * req_chan.quat_y;
         xz_ff <= req_chan.quat_x * req_chan.quat_z;
         wz_ff <= req_chan.quat_w * req_chan.quat_z;
         xy_ff <= req_chan.quat_x * req_chan.quat_y;
      end
   end

   // sum stage: atan2 operands and clamped pitch radicands
   qte_pkg::atan_pair_type             roll_in, yaw_in;
   logic signed [qte_pkg::SUM_BITS-1:0] t_s, ra_s, rb_s;
   logic [qte_pkg::RAD_BITS-1:0]        ra_in, rb_in;
   logic [qte_pkg::RAD_BITS-1:0]        sa_rad_ff, sb_rad_ff;
   qte_pkg::atan_pair_type             roll_d [SQ_STAGES+1];
   qte_pkg::atan_pair_type             yaw_d  [SQ_STAGES+1];
   qte_pkg::sqrt_vec_type              sa_d   [SQ_STAGES+1];
   qte_pkg::sqrt_vec_type              sb_d   [SQ_STAGES+1];

   always_comb begin
      roll_in.num = (qte_pkg::SUM_BITS'(wx_ff) + qte_pkg::SUM_BITS'(yz_ff)) <<< 1;
      roll_in.den = qte_pkg::ONE_Q -
                    ((qte_pkg::SUM_BITS'(xx_ff) + qte_pkg::SUM_BITS'(yy_ff)) <<< 1);
      yaw_in.num  = (qte_pkg::SUM_BITS'(wz_ff) + qte_pkg::SUM_BITS'(xy_ff)) <<< 1;
      yaw_in.den  = qte_pkg::ONE_Q -
                    ((qte_pkg::SUM_BITS'(yy_ff) + qte_pkg::SUM_BITS'(zz_ff)) <<< 1);
      t_s  = qte_pkg::SUM_BITS'(wy_ff) - qte_pkg::SUM_BITS'(xz_ff);
      ra_s = qte_pkg::ONE_Q + (t_s <<< 1);
      rb_s = qte_pkg::ONE_Q - (t_s <<< 1);
      ra_in = ra_s[qte_pkg::SUM_BITS-1] ? '0 : qte_pkg::RAD_BITS'(ra_s);
      rb_in = rb_s[qte_pkg::SUM_BITS-1] ? '0 : qte_pkg::RAD_BITS'(rb_s);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         roll_d[0] <= roll_in;
         yaw_d[0]  <= yaw_in;
         sa_rad_ff <= ra_in;
         sb_rad_ff <= rb_in;
      end
   end
   assign sa_d[0] = '{rad: sa_rad_ff, rem: '0, root: '0};
   assign sb_d[0] = '{rad: sb_rad_ff, rem: '0, root: '0};

   // square-root cells, roll and yaw operands ride alongside
   for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
      qte_sqrt_cell u_sa (
         .clock   (clock),
         .enable  (en[2+i]),
         .in_vec  (sa_d[i]),
         .out_vec (sa_d[i+1])
      );
      qte_sqrt_cell u_sb (
         .clock   (clock),
         .enable  (en[2+i]),
         .in_vec  (sb_d[i]),
         .out_vec (sb_d[i+1])
      );
      always_ff @(posedge clock) begin
         if (en[2+i]) begin
            roll_d[i+1] <= roll_d[i];
            yaw_d[i+1]  <= yaw_d[i];
         end
      end
   end

   // atan2 setup: zero vector flag, half-turn for negative x
   function automatic qte_pkg::cordic_vec_type atan_prep(input qte_pkg::atan_pair_type p);
      qte_pkg::cordic_vec_type     v;
      logic signed [qte_pkg::VEC_BITS-1:0] nx, ny;
      nx = qte_pkg::VEC_BITS'(p.den);
      ny = qte_pkg::VEC_BITS'(p.num);
      v.zero = (p.num == '0) && (p.den == '0);
      if (p.den[qte_pkg::SUM_BITS-1]) begin
         v.x   = -nx;
         v.y   = -ny;
         v.ang = p.num[qte_pkg::SUM_BITS-1] ? -qte_pkg::PI_Q30 : qte_pkg::PI_Q30;
      end else begin
         v.x   = nx;
         v.y   = ny;
         v.ang = '0;
      end
      return v;
   endfunction

   qte_pkg::cordic_vec_type roll_c  [CORDIC_STEPS+1];
   qte_pkg::cordic_vec_type pitch_c [CORDIC_STEPS+1];
   qte_pkg::cordic_vec_type yaw_c   [CORDIC_STEPS+1];
   qte_pkg::atan_pair_type  pitch_pair;

   assign pitch_pair.num = qte_pkg::SUM_BITS'(sa_d[SQ_STAGES].root);
   assign pitch_pair.den = qte_pkg::SUM_BITS'(sb_d[SQ_STAGES].root);

   always_ff @(posedge clock) begin
      if (en[PREP_IDX]) begin
         roll_c[0]  <= atan_prep(roll_d[SQ_STAGES]);
         pitch_c[0] <= atan_prep(pitch_pair);
         yaw_c[0]   <= atan_prep(yaw_d[SQ_STAGES]);
      end
   end

   // CORDIC cell rows
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      qte_cordic_cell #(.STEP(i)) u_roll (
         .clock   (clock),
         .enable  (en[PREP_IDX+1+i]),
         .in_vec  (roll_c[i]),
         .out_vec (roll_c[i+1])
      );
      qte_cordic_cell #(.STEP(i)) u_pitch (
         .clock   (clock),
         .enable  (en[PREP_IDX+1+i]),
         .in_vec  (pitch_c[i]),
         .out_vec (pitch_c[i+1])
      );
      qte_cordic_cell #(.STEP(i)) u_yaw (
         .clock   (clock),
         .enable  (en[PREP_IDX+1+i]),
         .in_vec  (yaw_c[i]),
         .out_vec (yaw_c[i+1])
      );
   end

   // round half up and saturate
   function automatic logic signed [qte_pkg::ACC_BITS-1:0] round_sat(
      input logic signed [qte_pkg::ACC_BITS-1:0] a,
      input logic signed [qte_pkg::ACC_BITS-1:0] lim
   );
      logic signed [qte_pkg::ACC_BITS-1:0] r;
      r = (a + qte_pkg::ROUND_HALF) >>> qte_pkg::OUT_SHIFT;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic signed [qte_pkg::ACC_BITS-1:0]   roll_a, pitch_a, yaw_a;
   logic signed [qte_pkg::ACC_BITS-1:0]   roll_r, pitch_r, yaw_r;
   logic signed [qte_pkg::ROLL_BITS-1:0]  roll_ff;
   logic signed [qte_pkg::PITCH_BITS-1:0] pitch_ff;
   logic signed [qte_pkg::YAW_BITS-1:0]   yaw_ff;

   always_comb begin
      roll_a  = roll_c[CORDIC_STEPS].zero ? '0 : roll_c[CORDIC_STEPS].ang;
      yaw_a   = yaw_c[CORDIC_STEPS].zero ? '0 : yaw_c[CORDIC_STEPS].ang;
      pitch_a = (pitch_c[CORDIC_STEPS].zero ? '0 : (pitch_c[CORDIC_STEPS].ang <<< 1))
                - qte_pkg::HALF_PI_Q30;
      roll_r  = round_sat(roll_a, qte_pkg::PI_LIM);
      pitch_r = round_sat(pitch_a, qte_pkg::HALF_PI_LIM);
      yaw_r   = round_sat(yaw_a, qte_pkg::PI_LIM);
   end

   // output register
   always_ff @(posedge clock) begin
      if (en[OUT_IDX]) begin
         roll_ff  <= qte_pkg::ROLL_BITS'(roll_r);
         pitch_ff <= qte_pkg::PITCH_BITS'(pitch_r);
         yaw_ff   <= qte_pkg::YAW_BITS'(yaw_r);
      end
   end

   assign rsp_chan.valid       = valid_ff[OUT_IDX];
   assign rsp_chan.roll_angle  = roll_ff;
   assign rsp_chan.pitch_angle = pitch_ff;
   assign rsp_chan.yaw_angle   = yaw_ff;

endmodule

[hdl/qte_checker.sv]
// ----------------------------------------------------------------------------
// qte_checker: port-level checks for quaternion_to_euler_angles
// Watches the response channel for stability, range and reset behavior.
// ----------------------------------------------------------------------------
module qte_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [qte_pkg::ROLL_BITS-1:0]  rsp_roll,
   input logic signed [qte_pkg::PITCH_BITS-1:0] rsp_pitch,
   input logic signed [qte_pkg::YAW_BITS-1:0]   rsp_yaw
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll) &&
      $stable(rsp_pitch) && $stable(rsp_yaw))
      else $error("response word changed while stalled");

   // pitch within a quarter turn either way
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch >= -15'sd12868 && rsp_pitch <= 15'sd12868)
      else $error("pitch out of range");

   // roll and yaw within a half turn either way
   a_ry_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll >= -16'sd25736 && rsp_roll <= 16'sd25736 &&
      rsp_yaw >= -16'sd25736 && rsp_yaw <= 16'sd25736)
      else $error("roll or yaw out of range");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_roll  (rsp_chan.roll_angle),
   .rsp_pitch (rsp_chan.pitch_angle),
   .rsp_yaw   (rsp_chan.yaw_angle)
);

[test/qte_check.sv]
// ----------------------------------------------------------------------------
// qte_check: angle predictor and response checker
// Watches both channels, computes roll, pitch and yaw for every accepted
// quaternion word and compares each response word with the oldest prediction.
// ----------------------------------------------------------------------------
module qte_check (
   input  logic      clock,
   input  logic      reset,
   qte_req_if.sink   req_mon,
   qte_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending
);

   typedef struct {
      logic signed [qte_pkg::ROLL_BITS-1:0]  roll;
      logic signed [qte_pkg::PITCH_BITS-1:0] pitch;
      logic signed [qte_pkg::YAW_BITS-1:0]   yaw;
   } angles_type;

   angles_type angle_queue[$];

   localparam longint PI_FIX      = 64'sd3373259426;
   localparam longint HALF_PI_FIX = 64'sd1686629713;
   localparam int     STEPS       = 16;

   longint arctan_tab[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};

   // floor square root, bit by bit
   function automatic longint floor_root(input longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // vectoring cordic, angle with 30 fraction bits
   function automatic longint vector_angle(input longint y, input longint x);
      longint offs, z, dx, dy;
      offs = 0;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         offs = (y >= 0) ? PI_FIX : -PI_FIX;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += arctan_tab[i];
         end else begin
            x -= dx;
            y += dy;
            z -= arctan_tab[i];
         end
      end
      return offs + z;
   endfunction

   // round half up to output scale, then clamp
   function automatic longint round_clamp(input longint a, input longint lim_fix);
      longint lim, r;
      lim = (lim_fix + (64'sd1 <<< (qte_pkg::OUT_SHIFT - 1))) >>> qte_pkg::OUT_SHIFT;
      r = (a + (64'sd1 <<< (qte_pkg::OUT_SHIFT - 1))) >>> qte_pkg::OUT_SHIFT;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_of(input longint w, x, y, z);
      angles_type e;
      longint one, t, ra, rb, p;
      one = 64'sd1 <<< (2 * qte_pkg::QUAT_FRAC_BITS);
      e.roll = qte_pkg::ROLL_BITS'(round_clamp(vector_angle(2 * (w * x + y * z),
         one - 2 * (x * x + y * y)), PI_FIX));
      t = w * y - x * z;
      ra = one + 2 * t;
      rb = one - 2 * t;
      if (ra < 0) ra = 0;
      if (rb < 0) rb = 0;
      p = 2 * vector_angle(floor_root(ra), floor_root(rb)) - HALF_PI_FIX;
      e.pitch = qte_pkg::PITCH_BITS'(round_clamp(p, HALF_PI_FIX));
      e.yaw = qte_pkg::YAW_BITS'(round_clamp(vector_angle(2 * (w * z + x * y),
         one - 2 * (y * y + z * z)), PI_FIX));
      return e;
   endfunction

   // predict on request words, compare on response words
   always @(posedge clock) begin
      angles_type e;
      int         nerr;
      nerr = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            angle_queue.push_back(euler_of(req_mon.quat_w, req_mon.quat_x,
               req_mon.quat_y, req_mon.quat_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (angle_queue.size() == 0) begin
               $error("response word with nothing expected");
               nerr++;
            end else begin
               e = angle_queue.pop_front();
               if (e.roll !== rsp_mon.roll_angle) begin
                  $error("roll_angle expected %0d got %0d", e.roll, rsp_mon.roll_angle);
                  nerr++;
               end
               if (e.pitch !== rsp_mon.pitch_angle) begin
                  $error("pitch_angle expected %0d got %0d", e.pitch,
                     rsp_mon.pitch_angle);
                  nerr++;
               end
               if (e.yaw !== rsp_mon.yaw_angle) begin
                  $error("yaw_angle expected %0d got %0d", e.yaw, rsp_mon.yaw_angle);
                  nerr++;
               end
            end
         end
         fail_count <= fail_count + nerr;
      end
      pending = angle_queue.size();
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: quaternion to Euler angle testbench
// Drives directed and random quaternion words with random gaps and response
// stalls, including a long stall that fills the pipe and a drain pause.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_WORDS = 1900;
   localparam int LATENCY      = 37;
   localparam longint CYCLE_LIMIT = 400000;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   int     fail_count;
   int     pending;
   longint cycles = 0;
   bit     hold_rsp = 1'b0;
   bit     hold_done = 1'b0;

   qte_req_if req_chan ();
   qte_rsp_if rsp_chan ();

   quaternion_to_euler_angles u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   qte_check u_check (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending(pending));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] rand_comp();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
      return 16'($urandom);
   endfunction

   // one quaternion word, held until taken
   task automatic send_word(input logic [15:0] w, x, y, z);
      req_chan.quat_w <= w;
      req_chan.quat_x <= x;
      req_chan.quat_y <= y;
      req_chan.quat_z <= z;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // response side: random stalls, one long hold
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int g;
         if (hold_rsp && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_done = 1'b1;
         end
         g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (g > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      logic [15:0] q[4];
      int s;
      req_chan.valid = 1'b0;
      req_chan.quat_w = '0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity, axis turns, extremes, zero vector, negative radicand
      send_word(16'sd16384, 0, 0, 0);
      send_word(0, 16'sd16384, 0, 0);
      send_word(0, 0, 16'sd16384, 0);
      send_word(0, 0, 0, 16'sd16384);
      send_word(-16'sd16384, 0, 0, 0);
      send_word(0, -16'sd16384, 0, 0);
      send_word(0, 0, -16'sd16384, 0);
      send_word(0, 0, 0, -16'sd16384);
      send_word(0, 0, 0, 0);
      send_word(16'sd11585, 0, 16'sd11585, 0);
      send_word(16'sd11585, 0, -16'sd11585, 0);
      send_word(16'sd11585, 16'sd11585, 0, 0);
      send_word(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
      send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_word(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_word(16'h7FFF, 0, 16'h7FFF, 0);
      send_word(16'h7FFF, 0, 16'h8000, 0);
      send_word(0, 16'h7FFF, 16'h7FFF, 0);
      send_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
      send_word(0, 16'sd100, 0, 0);

      // random part; long response hold partway, drain pause later
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 400) hold_rsp = 1'b1;
         if (i == 1000) begin
            idle_gap(1);
            while (pending != 0) @(negedge clock);
         end
         for (int k = 0; k < 4; k++) q[k] = rand_comp();
         send_word(q[0], q[1], q[2], q[3]);
         if (i > 450 && i < 1500) begin
            s = gap_len();
            if (s > 0) idle_gap(s);
         end
      end
      idle_gap(1);

      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
